// File: rtl/assert_macros.svh
// Assertion macros for the journal RTL core.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check while out of reset
`define CFJ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// check across reset as well
`define CFJ_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/cfj_pkg.sv
// Package for the flash record journal: command and status codes, marker
// words, request/result/state types and the 96-bit record CRC-32 network.
// No dependencies.
package cfj_pkg;

    localparam int SLOT_W     = 12;
    localparam int SLOT_CNT_W = 13;

    localparam logic [SLOT_CNT_W-1:0] MAX_SLOTS = 13'd4096;

    localparam logic [2:0] CMD_BEGIN_SCAN  = 3'd0;
    localparam logic [2:0] CMD_SCAN_RECORD = 3'd1;
    localparam logic [2:0] CMD_STORE       = 3'd2;
    localparam logic [2:0] CMD_MARK_MOVING = 3'd3;
    localparam logic [2:0] CMD_WRITE_DONE  = 3'd4;

    localparam logic [1:0] WST_OK         = 2'd0;
    localparam logic [1:0] WST_ERASE_FAIL = 2'd1;

    localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
    localparam logic [31:0] MARK_VALID   = 32'h56414C44;
    localparam logic [31:0] MARK_INVALID = 32'h494E5644;
    localparam logic [31:0] SEQ_ERASED   = 32'hFFFFFFFF;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [SLOT_W-1:0] slot_index;
        logic [31:0]       rec_seq;
        logic [31:0]       rec_position;
        logic [31:0]       rec_marker;
        logic [31:0]       rec_check;
        logic [31:0]       store_position;
        logic [1:0]        write_status;
    } t_req;

    typedef struct packed {
        logic              write_request;
        logic              erase_first;
        logic [SLOT_W-1:0] write_slot;
        logic [31:0]       write_seq;
        logic [31:0]       write_position;
        logic [31:0]       write_marker;
        logic [31:0]       write_check;
        logic              has_valid_stored;
        logic              has_any_record;
        logic [31:0]       latest_position_out;
    } t_rsp;

    typedef struct packed {
        logic [31:0]           next_sequence;
        logic [SLOT_CNT_W-1:0] next_slot;
        logic                  record_known;
        logic [31:0]           latest_marker;
        logic [31:0]           latest_position;
        logic                  write_pending;
        logic                  pending_erase;
        logic [31:0]           pending_marker;
        logic [31:0]           pending_position;
    } t_state;

    localparam t_state STATE_CLEAR = '{
        next_sequence:    32'd0,
        next_slot:        '0,
        record_known:     1'b0,
        latest_marker:    MARK_INVALID,
        latest_position:  32'd0,
        write_pending:    1'b0,
        pending_erase:    1'b0,
        pending_marker:   32'd0,
        pending_position: 32'd0
    };

    typedef logic [95:0][31:0] t_crc_cols;

    // bit-serial form, evaluated at elaboration only
    function automatic logic [31:0] crc_raw(input logic [95:0] d);
        logic [31:0] c;
        logic        fb;
        c = '1;
        for (int j = 0; j < 96; j++) begin
            fb = c[0] ^ d[j];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic t_crc_cols crc_cols();
        t_crc_cols cols;
        for (int i = 0; i < 96; i++) begin
            cols[i] = crc_raw(96'd1 << i) ^ crc_raw(96'd0);
        end
        return cols;
    endfunction

    localparam t_crc_cols   CRC_COLS = crc_cols();
    localparam logic [31:0] CRC_BASE = ~crc_raw(96'd0);

    // flat XOR network over seq, position, marker, little-endian
    function automatic logic [31:0] crc_record(
        input logic [31:0] seq,
        input logic [31:0] pos,
        input logic [31:0] mark
    );
        logic [95:0] d;
        logic [31:0] c;
        d = {mark, pos, seq};
        c = CRC_BASE;
        for (int i = 0; i < 96; i++) begin
            if (d[i]) begin
                c = c ^ CRC_COLS[i];
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/cfj_ifs.sv
// Valid/ready channel interfaces for journal requests and results.
// Depends on cfj_pkg for field widths.
interface cfj_req_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                cmd;
    logic [cfj_pkg::SLOT_W-1:0] slot_index;
    logic [31:0]               rec_seq;
    logic [31:0]               rec_position;
    logic [31:0]               rec_marker;
    logic [31:0]               rec_check;
    logic [31:0]               store_position;
    logic [1:0]                write_status;

    modport source (
        output valid, cmd, slot_index, rec_seq, rec_position, rec_marker,
               rec_check, store_position, write_status,
        input  ready
    );
    modport sink (
        input  valid, cmd, slot_index, rec_seq, rec_position, rec_marker,
               rec_check, store_position, write_status,
        output ready
    );
endinterface

interface cfj_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      write_request;
    logic                      erase_first;
    logic [cfj_pkg::SLOT_W-1:0] write_slot;
    logic [31:0]               write_seq;
    logic [31:0]               write_position;
    logic [31:0]               write_marker;
    logic [31:0]               write_check;
    logic                      has_valid_stored;
    logic                      has_any_record;
    logic [31:0]               latest_position_out;

    modport source (
        output valid, write_request, erase_first, write_slot, write_seq,
               write_position, write_marker, write_check, has_valid_stored,
               has_any_record, latest_position_out,
        input  ready
    );
    modport sink (
        input  valid, write_request, erase_first, write_slot, write_seq,
               write_position, write_marker, write_check, has_valid_stored,
               has_any_record, latest_position_out,
        output ready
    );
endinterface

// File: rtl/crc_guarded_flash_record_journal_core.sv
// Flash record journal controller: scan recovery, write requests, commit.
// Depends on cfj_pkg, cfj_ifs.sv and assert_macros.svh.
//
//   port         dir   handshake        carries
//   i_req        in    valid/ready      one command request per transfer
//   o_rsp        out   valid/ready      one result per request
//   i_cfg_we     in    write enable     slot_count (i_cfg_wdata)
//
// One request per cycle sustained while o_rsp is ready; stages are the input
// and result registers. Journal state updates as a request moves to the result
// register; the CRC networks and the sequence compare sit in that one stage.
// Synchronous active-low reset clears both stages and the journal state.
// A stalled o_rsp holds the result; i_req keeps flowing until both stages fill.
`include "assert_macros.svh"

module crc_guarded_flash_record_journal_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cfj_pkg::SLOT_CNT_W-1:0]    i_cfg_wdata,
    cfj_req_if.sink                           i_req,
    cfj_rsp_if.source                         o_rsp
);

    logic                           r_in_valid;
    cfj_pkg::t_req                  r_in;
    logic                           r_out_valid;
    cfj_pkg::t_rsp                  r_out;
    cfj_pkg::t_state                r_st;
    cfj_pkg::t_state                n_st;
    cfj_pkg::t_rsp                  n_rsp;
    logic [cfj_pkg::SLOT_CNT_W-1:0] r_slot_count;

    cfj_pkg::t_req                  w_req;
    logic                           w_adv;
    logic [cfj_pkg::SLOT_CNT_W-1:0] w_eff;
    logic [31:0]                    w_scan_crc;
    logic                           w_scan_good;
    logic                           w_iss;
    logic [31:0]                    w_iss_pos;
    logic [31:0]                    w_iss_mark;
    logic                           w_erase;

    assign w_req = '{
        cmd:            i_req.cmd,
        slot_index:     i_req.slot_index,
        rec_seq:        i_req.rec_seq,
        rec_position:   i_req.rec_position,
        rec_marker:     i_req.rec_marker,
        rec_check:      i_req.rec_check,
        store_position: i_req.store_position,
        write_status:   i_req.write_status
    };

    assign w_adv       = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_adv;

    always_comb begin
        n_st        = r_st;
        n_rsp       = '0;
        w_iss       = 1'b0;
        w_iss_pos   = r_in.store_position;
        w_iss_mark  = cfj_pkg::MARK_VALID;
        w_eff       = (r_slot_count > cfj_pkg::MAX_SLOTS) ? cfj_pkg::MAX_SLOTS : r_slot_count;
        w_erase     = r_st.next_slot >= w_eff;
        w_scan_crc  = cfj_pkg::crc_record(r_in.rec_seq, r_in.rec_position, r_in.rec_marker);
        w_scan_good = ({1'b0, r_in.slot_index} < w_eff)
                      && (r_in.rec_seq != cfj_pkg::SEQ_ERASED)
                      && (w_scan_crc == r_in.rec_check);

        unique case (r_in.cmd)
            cfj_pkg::CMD_BEGIN_SCAN: begin
                n_st = cfj_pkg::STATE_CLEAR;
            end
            cfj_pkg::CMD_SCAN_RECORD: begin
                if (w_scan_good && (!r_st.record_known
                        || r_in.rec_seq >= r_st.next_sequence - 32'd1)) begin
                    n_st.next_sequence   = r_in.rec_seq + 32'd1;
                    n_st.next_slot       = {1'b0, r_in.slot_index} + 13'd1;
                    n_st.latest_marker   = r_in.rec_marker;
                    n_st.latest_position = r_in.rec_position;
                    n_st.record_known    = 1'b1;
                end
            end
            cfj_pkg::CMD_STORE: begin
                w_iss = 1'b1;
            end
            cfj_pkg::CMD_MARK_MOVING: begin
                w_iss      = r_st.latest_marker != cfj_pkg::MARK_INVALID;
                w_iss_pos  = r_st.latest_position;
                w_iss_mark = cfj_pkg::MARK_INVALID;
            end
            cfj_pkg::CMD_WRITE_DONE: begin
                if (r_st.write_pending) begin
                    if (r_in.write_status == cfj_pkg::WST_OK) begin
                        n_st.next_slot = (r_st.pending_erase ? '0 : r_st.next_slot)
                                         + 13'd1;
                        n_st.next_sequence   = r_st.next_sequence + 32'd1;
                        n_st.record_known    = 1'b1;
                        n_st.latest_marker   = r_st.pending_marker;
                        n_st.latest_position = r_st.pending_position;
                    end else if (r_in.write_status != cfj_pkg::WST_ERASE_FAIL) begin
                        if (r_st.pending_erase) begin
                            n_st.next_slot = '0;
                        end
                    end
                    n_st.write_pending = 1'b0;
                    n_st.pending_erase = 1'b0;
                end
            end
            default: begin
            end
        endcase

        if (w_iss && w_eff != '0 && !r_st.write_pending) begin
            n_st.write_pending    = 1'b1;
            n_st.pending_erase    = w_erase;
            n_st.pending_marker   = w_iss_mark;
            n_st.pending_position = w_iss_pos;
            n_rsp.write_request   = 1'b1;
            n_rsp.erase_first     = w_erase;
            n_rsp.write_slot      = w_erase ? '0 : r_st.next_slot[cfj_pkg::SLOT_W-1:0];
            n_rsp.write_seq       = r_st.next_sequence;
            n_rsp.write_position  = w_iss_pos;
            n_rsp.write_marker    = w_iss_mark;
            n_rsp.write_check     = cfj_pkg::crc_record(r_st.next_sequence, w_iss_pos,
                                                        w_iss_mark);
        end

        n_rsp.has_valid_stored    = n_st.record_known
                                    && (n_st.latest_marker == cfj_pkg::MARK_VALID);
        n_rsp.has_any_record      = n_st.record_known;
        n_rsp.latest_position_out = n_st.latest_position;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_st         <= cfj_pkg::STATE_CLEAR;
            r_slot_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_slot_count <= i_cfg_wdata;
            end
            if (i_req.valid && i_req.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_st        <= n_st;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= w_req;
        end
        if (w_adv) begin
            r_out <= n_rsp;
        end
    end

    assign o_rsp.valid               = r_out_valid;
    assign o_rsp.write_request       = r_out.write_request;
    assign o_rsp.erase_first         = r_out.erase_first;
    assign o_rsp.write_slot          = r_out.write_slot;
    assign o_rsp.write_seq           = r_out.write_seq;
    assign o_rsp.write_position      = r_out.write_position;
    assign o_rsp.write_marker        = r_out.write_marker;
    assign o_rsp.write_check         = r_out.write_check;
    assign o_rsp.has_valid_stored    = r_out.has_valid_stored;
    assign o_rsp.has_any_record      = r_out.has_any_record;
    assign o_rsp.latest_position_out = r_out.latest_position_out;

    `CFJ_ASSERT(a_issue_only_idle, w_adv && n_rsp.write_request |-> !r_st.write_pending, "write issued while pending")
    `CFJ_ASSERT(a_issue_sets_pending, w_adv && n_rsp.write_request |=> r_st.write_pending, "issued write not pending")
    `CFJ_ASSERT(a_erase_slot_zero, r_out_valid && r_out.erase_first |-> r_out.write_request && r_out.write_slot == '0, "erase request with nonzero slot")
    `CFJ_ASSERT_RST(a_reset_empties, !i_rst_n |=> !r_in_valid && !r_out_valid, "stages not cleared by reset")

endmodule

// File: tb/testbench.sv
// Testbench for crc_guarded_flash_record_journal_core: directed and random request
// streams, checked against a cycle-free journal predictor with its own CRC-32.
// Depends on cfj_pkg and the channel interfaces in cfj_ifs.sv.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cfj_pkg::*;

    localparam logic [2:0] CMD_UNKNOWN_HI = 3'd7;
    localparam logic [1:0] WST_PROG_FAIL  = 2'd2;
    localparam logic [1:0] WST_RESERVED   = 2'd3;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 1000;
    localparam int RSP_HOLD_LEN  = 64;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [SLOT_CNT_W-1:0] i_cfg_wdata;

    cfj_req_if req_ch();
    cfj_rsp_if rsp_ch();

    crc_guarded_flash_record_journal_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    // journal shadow state
    logic [SLOT_CNT_W-1:0] slot_count_cfg;
    logic [31:0]           seq_next;
    logic [SLOT_CNT_W-1:0] slot_next;
    logic                  rec_known;
    logic [31:0]           last_marker;
    logic [31:0]           last_pos;
    logic                  wr_pending;
    logic                  wr_erase;
    logic [31:0]           wr_marker;
    logic [31:0]           wr_pos;

    t_rsp expected_results[$];
    int   err_cnt = 0;
    int   src_idle_pct = 6;
    int   snk_idle_pct = 6;
    int   rsp_hold_cycles = 0;
    int   hold_req_cnt = 0;
    int   hold_ack_cnt = 0;
    int   stall_cycles = 0;

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] journal_crc(input logic [31:0] seq, pos, mark);
        logic [95:0] stream;
        logic [31:0] acc;
        logic        fb;
        stream = {mark, pos, seq};
        acc = '1;
        for (int b = 0; b < 96; b++) begin
            fb  = acc[0] ^ stream[b];
            acc = acc >> 1;
            if (fb) begin
                acc = acc ^ CRC_POLY;
            end
        end
        return ~acc;
    endfunction

    function automatic logic [SLOT_CNT_W-1:0] usable_slots();
        return (slot_count_cfg > MAX_SLOTS) ? MAX_SLOTS : slot_count_cfg;
    endfunction

    task automatic clear_journal();
        seq_next    = '0;
        slot_next   = '0;
        rec_known   = 1'b0;
        last_marker = MARK_INVALID;
        last_pos    = '0;
        wr_pending  = 1'b0;
        wr_erase    = 1'b0;
        wr_marker   = '0;
        wr_pos      = '0;
    endtask

    task automatic predict_journal(input t_req r);
        t_rsp                  res;
        logic                  do_issue;
        logic                  erase;
        logic [31:0]           ipos;
        logic [31:0]           imark;
        logic [SLOT_CNT_W-1:0] n;
        res      = '0;
        do_issue = 1'b0;
        ipos     = '0;
        imark    = '0;
        n        = usable_slots();
        case (r.cmd)
            CMD_BEGIN_SCAN: begin
                clear_journal();
            end
            CMD_SCAN_RECORD: begin
                if ({1'b0, r.slot_index} < n && r.rec_seq != SEQ_ERASED &&
                    journal_crc(r.rec_seq, r.rec_position, r.rec_marker) == r.rec_check &&
                    (!rec_known || r.rec_seq >= seq_next - 32'd1)) begin
                    seq_next    = r.rec_seq + 32'd1;
                    slot_next   = {1'b0, r.slot_index} + 13'd1;
                    last_marker = r.rec_marker;
                    last_pos    = r.rec_position;
                    rec_known   = 1'b1;
                end
            end
            CMD_STORE: begin
                do_issue = 1'b1;
                ipos     = r.store_position;
                imark    = MARK_VALID;
            end
            CMD_MARK_MOVING: begin
                if (last_marker != MARK_INVALID) begin
                    do_issue = 1'b1;
                    ipos     = last_pos;
                    imark    = MARK_INVALID;
                end
            end
            CMD_WRITE_DONE: begin
                if (wr_pending) begin
                    if (r.write_status == WST_OK) begin
                        if (wr_erase) begin
                            slot_next = '0;
                        end
                        slot_next   = slot_next + 13'd1;
                        seq_next    = seq_next + 32'd1;
                        rec_known   = 1'b1;
                        last_marker = wr_marker;
                        last_pos    = wr_pos;
                    end else if (r.write_status != WST_ERASE_FAIL) begin
                        if (wr_erase) begin
                            slot_next = '0;
                        end
                    end
                    wr_pending = 1'b0;
                    wr_erase   = 1'b0;
                end
            end
            default: begin
            end
        endcase
        if (do_issue && n != 0 && !wr_pending) begin
            erase              = (slot_next >= n);
            res.write_request  = 1'b1;
            res.erase_first    = erase;
            res.write_slot     = erase ? '0 : slot_next[SLOT_W-1:0];
            res.write_seq      = seq_next;
            res.write_position = ipos;
            res.write_marker   = imark;
            res.write_check    = journal_crc(seq_next, ipos, imark);
            wr_pending         = 1'b1;
            wr_erase           = erase;
            wr_marker          = imark;
            wr_pos             = ipos;
        end
        res.has_valid_stored    = rec_known && last_marker == MARK_VALID;
        res.has_any_record      = rec_known;
        res.latest_position_out = last_pos;
        expected_results.push_back(res);
    endtask

    function automatic t_req rand_req();
        t_req r;
        r.cmd            = 3'($urandom_range(7));
        r.slot_index     = 12'($urandom);
        r.rec_seq        = $urandom;
        r.rec_position   = $urandom;
        r.rec_marker     = $urandom;
        r.rec_check      = $urandom;
        r.store_position = $urandom;
        r.write_status   = 2'($urandom_range(3));
        return r;
    endfunction

    function automatic t_req op_req(input logic [2:0] cmd);
        t_req r;
        r     = rand_req();
        r.cmd = cmd;
        return r;
    endfunction

    function automatic t_req scan_req(input logic [11:0] slot,
                                      input logic [31:0] seq, pos, mark);
        t_req r;
        r              = op_req(CMD_SCAN_RECORD);
        r.slot_index   = slot;
        r.rec_seq      = seq;
        r.rec_position = pos;
        r.rec_marker   = mark;
        r.rec_check    = journal_crc(seq, pos, mark);
        return r;
    endfunction

    function automatic t_req store_req(input logic [31:0] pos);
        t_req r;
        r                = op_req(CMD_STORE);
        r.store_position = pos;
        return r;
    endfunction

    function automatic t_req done_req(input logic [1:0] status);
        t_req r;
        r              = op_req(CMD_WRITE_DONE);
        r.write_status = status;
        return r;
    endfunction

    function automatic logic [31:0] pick_marker();
        int roll;
        roll = $urandom_range(9);
        if (roll < 6) begin
            return MARK_VALID;
        end else if (roll < 9) begin
            return MARK_INVALID;
        end
        return $urandom;
    endfunction

    task automatic send_req(input t_req r);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.cmd            <= r.cmd;
        req_ch.slot_index     <= r.slot_index;
        req_ch.rec_seq        <= r.rec_seq;
        req_ch.rec_position   <= r.rec_position;
        req_ch.rec_marker     <= r.rec_marker;
        req_ch.rec_check      <= r.rec_check;
        req_ch.store_position <= r.store_position;
        req_ch.write_status   <= r.write_status;
        do begin
            @(posedge i_clk);
        end while (!req_ch.ready);
        predict_journal(r);
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_slot_count(input logic [SLOT_CNT_W-1:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        slot_count_cfg = value;
    endtask

    task automatic flag_error(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic cmp_field(input string name, input logic [31:0] got, want);
        if (got !== want) begin
            flag_error($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp got;
        t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.write_request       = rsp_ch.write_request;
            got.erase_first         = rsp_ch.erase_first;
            got.write_slot          = rsp_ch.write_slot;
            got.write_seq           = rsp_ch.write_seq;
            got.write_position      = rsp_ch.write_position;
            got.write_marker        = rsp_ch.write_marker;
            got.write_check         = rsp_ch.write_check;
            got.has_valid_stored    = rsp_ch.has_valid_stored;
            got.has_any_record      = rsp_ch.has_any_record;
            got.latest_position_out = rsp_ch.latest_position_out;
            if (expected_results.size() == 0) begin
                flag_error("result with no request outstanding");
            end else begin
                want = expected_results.pop_front();
                cmp_field("write_request", got.write_request, want.write_request);
                cmp_field("erase_first", got.erase_first, want.erase_first);
                cmp_field("write_slot", got.write_slot, want.write_slot);
                cmp_field("write_seq", got.write_seq, want.write_seq);
                cmp_field("write_position", got.write_position, want.write_position);
                cmp_field("write_marker", got.write_marker, want.write_marker);
                cmp_field("write_check", got.write_check, want.write_check);
                cmp_field("has_valid_stored", got.has_valid_stored, want.has_valid_stored);
                cmp_field("has_any_record", got.has_any_record, want.has_any_record);
                cmp_field("latest_position_out", got.latest_position_out,
                          want.latest_position_out);
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_req_cnt != hold_ack_cnt) begin
            rsp_ch.ready    <= 1'b0;
            hold_ack_cnt    <= hold_req_cnt;
            rsp_hold_cycles <= RSP_HOLD_LEN - 1;
        end else if (rsp_hold_cycles != 0) begin
            rsp_ch.ready    <= 1'b0;
            rsp_hold_cycles <= rsp_hold_cycles - 1;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic run_journal_traffic(input int n_items);
        int                    sent;
        int                    pick;
        int                    burst;
        logic [31:0]           seq_base;
        logic [11:0]           slot;
        logic [SLOT_CNT_W-1:0] n;
        t_req                  r;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            n    = usable_slots();
            if (pick < 14) begin
                send_req(op_req(CMD_BEGIN_SCAN));
                sent++;
                burst    = $urandom_range(1, 8);
                seq_base = ($urandom_range(9) == 0) ? SEQ_ERASED - 32'($urandom_range(4))
                                                    : $urandom;
                slot     = (n == 0) ? 12'($urandom) : 12'($urandom_range(int'(n) - 1));
                repeat (burst) begin
                    r = scan_req(slot, seq_base, $urandom, pick_marker());
                    if ($urandom_range(9) == 0) begin
                        r.rec_check = r.rec_check ^ (32'd1 << $urandom_range(31));
                    end
                    send_req(r);
                    sent++;
                    seq_base = seq_base + 32'($urandom_range(3)) - 32'd1;
                    slot = (n == 0) ? 12'($urandom) : 12'((int'(slot) + 1) % int'(n));
                end
            end else if (pick < 78) begin
                if ($urandom_range(99) < 65) begin
                    send_req(store_req($urandom));
                end else begin
                    send_req(op_req(CMD_MARK_MOVING));
                end
                sent++;
                if ($urandom_range(9) == 0) begin
                    send_req(rand_req());
                    sent++;
                end
                pick = $urandom_range(99);
                if (pick < 70) begin
                    send_req(done_req(WST_OK));
                end else if (pick < 80) begin
                    send_req(done_req(WST_ERASE_FAIL));
                end else if (pick < 90) begin
                    send_req(done_req(WST_PROG_FAIL));
                end else begin
                    send_req(done_req(WST_RESERVED));
                end
                sent++;
            end else begin
                case ($urandom_range(3))
                    0: r = rand_req();
                    1: r = scan_req(12'($urandom), $urandom, $urandom, pick_marker());
                    2: r = scan_req(12'($urandom), SEQ_ERASED, $urandom, MARK_VALID);
                    default: r = op_req(CMD_SCAN_RECORD);
                endcase
                send_req(r);
                sent++;
            end
        end
    endtask

    task automatic test_empty_region();
        set_slot_count(13'd0);
        send_req(store_req(32'hFFFF_FFFF));
        send_req(op_req(CMD_MARK_MOVING));
        send_req(done_req(WST_OK));
        send_req(scan_req(12'd0, 32'd5, 32'h1234_5678, MARK_VALID));
        send_req(op_req(CMD_UNKNOWN_HI));
    endtask

    task automatic test_scan_recovery();
        t_req r;
        set_slot_count(13'd16);
        send_req(op_req(CMD_BEGIN_SCAN));
        send_req(scan_req(12'd3, 32'd10, 32'd0, MARK_VALID));
        send_req(scan_req(12'd5, 32'd10, 32'hFFFF_FFFF, MARK_VALID));
        send_req(scan_req(12'd7, 32'd9, 32'hA5A5_A5A5, MARK_VALID));
        r           = scan_req(12'd8, 32'd20, 32'h0F0F_0F0F, MARK_VALID);
        r.rec_check = ~r.rec_check;
        send_req(r);
        send_req(scan_req(12'd9, SEQ_ERASED, 32'h5555_5555, MARK_VALID));
        send_req(scan_req(12'd16, 32'd30, 32'h3333_3333, MARK_VALID));
    endtask

    task automatic test_write_paths();
        send_req(store_req(32'h0000_0000));
        send_req(store_req(32'h1111_1111));
        send_req(done_req(WST_ERASE_FAIL));
        send_req(op_req(CMD_MARK_MOVING));
        send_req(done_req(WST_RESERVED));
        send_req(store_req(32'hDEAD_BEEF));
        send_req(done_req(WST_OK));
        send_req(op_req(CMD_MARK_MOVING));
        send_req(op_req(CMD_BEGIN_SCAN));
        send_req(op_req(CMD_MARK_MOVING));
    endtask

    task automatic test_sequence_wrap();
        set_slot_count(13'h1FFF);
        send_req(op_req(CMD_BEGIN_SCAN));
        send_req(scan_req(12'hFFF, 32'hFFFF_FFFE, 32'h8000_0001, MARK_VALID));
        send_req(store_req(32'h7FFF_FFFE));
        send_req(done_req(WST_PROG_FAIL));
        send_req(store_req(32'hC3C3_3C3C));
        send_req(done_req(WST_OK));
    endtask

    task automatic test_random_journal();
        logic [SLOT_CNT_W-1:0] phase_slots [6];
        phase_slots = '{13'd4, 13'd1, 13'd4096, 13'd2, 13'd4097, 13'd8191};
        for (int p = 0; p < 6; p++) begin
            set_slot_count(phase_slots[p]);
            src_idle_pct = (p == 0) ? 0 : 6;
            snk_idle_pct = (p == 0) ? 0 : 6;
            run_journal_traffic(280);
        end
    endtask

    task automatic test_backpressure();
        set_slot_count(13'd8);
        src_idle_pct = 0;
        hold_req_cnt++;
        run_journal_traffic(40);
        src_idle_pct = 6;
    endtask

    initial begin
        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_wdata           <= '0;
        req_ch.valid          <= 1'b0;
        req_ch.cmd            <= CMD_BEGIN_SCAN;
        req_ch.slot_index     <= '0;
        req_ch.rec_seq        <= '0;
        req_ch.rec_position   <= '0;
        req_ch.rec_marker     <= '0;
        req_ch.rec_check      <= '0;
        req_ch.store_position <= '0;
        req_ch.write_status   <= WST_OK;
        slot_count_cfg = '0;
        clear_journal();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_region();
        test_scan_recovery();
        test_write_paths();
        test_sequence_wrap();
        test_random_journal();
        test_backpressure();

        wait_idle();
        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
